FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("design check failed");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: design/ocfrm_pkg.sv
// ----------------------------------------------------------------------------
// ocfrm_pkg
// types, constants, microcode and angle table of the omni chassis mixer
// ----------------------------------------------------------------------------
`default_nettype none

package ocfrm_pkg;

  // rotation iterations, legal range 8 to 24
  localparam int CORDIC_STEPS = 16;

  localparam int NUM_WHEELS = 4;
  localparam int IterW      = 5;
  localparam int VEC_W      = 34;
  localparam int ANG_W      = 33;
  localparam int KPART_W    = 15;
  localparam int P_W        = VEC_W + KPART_W + 1;
  localparam int ACC_W      = 64;
  localparam int ACC_SHIFT  = 44;
  localparam int Q_W        = ACC_W - ACC_SHIFT;
  localparam int HELD_W     = 17;
  localparam int SUM_W      = HELD_W + 1;
  localparam int GAIN_W     = 18;
  localparam int MP_W       = SUM_W + GAIN_W + 1;
  localparam int RND_W      = MP_W - 8;
  localparam int SET_W      = 24;
  localparam int PC_W       = 4;
  localparam int CMD_W      = 16;

  // infinite-step cordic gain, Q30
  localparam logic [2*KPART_W-1:0] CORDIC_K = 30'd652032874;

  localparam logic signed [ACC_W-1:0] ACC_ROUND = 64'sh0000_0800_0000_0000;

  localparam logic signed [Q_W-1:0]    HELD_MAX_Q = 20'sd65535;
  localparam logic signed [Q_W-1:0]    HELD_MIN_Q = -20'sd65536;
  localparam logic signed [HELD_W-1:0] HELD_MAX   = 17'sh0FFFF;
  localparam logic signed [HELD_W-1:0] HELD_MIN   = 17'sh10000;

  localparam logic signed [RND_W-1:0] SET_MAX_R = 29'sd8388607;
  localparam logic signed [RND_W-1:0] SET_MIN_R = -29'sd8388608;
  localparam logic signed [SET_W-1:0] SET_MAX   = 24'sh7FFFFF;
  localparam logic signed [SET_W-1:0] SET_MIN   = 24'sh800000;

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_A = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 8'd3;

  typedef enum logic [1:0] {
    MODE_STOP       = 2'd0,
    MODE_NO_FOLLOW  = 2'd1,
    MODE_FOLLOW_YAW = 2'd2,
    MODE_KEEP       = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    WHEEL_A = 2'd0,
    WHEEL_B = 2'd1,
    WHEEL_C = 2'd2,
    WHEEL_D = 2'd3
  } wheel_t;

  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NONE      = 2'd0,
    JMP_NO_ROT    = 2'd1,
    JMP_ITER_MORE = 2'd2
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_RUN  = 1'b1
  } seq_state_t;

  // one control word of the program
  typedef struct packed {
    logic            init;
    logic            iter;
    logic            mul_en;
    logic            mul_hi;
    logic            mul_src_y;
    acc_op_t         acc_op;
    logic            fin_en;
    logic            fin_y;
    logic            mix_mul;
    wheel_t          mix_wheel;
    logic            mix_rnd;
    wheel_t          rnd_wheel;
    logic            last;
    jmp_t            jmp;
    logic [PC_W-1:0] target;
  } ucode_t;

  // datapath flags seen by the jump logic
  typedef struct packed {
    logic no_rot;
    logic iter_more;
  } dp_stat_t;

  localparam logic [PC_W-1:0] PC_INIT = 4'd0;
  localparam logic [PC_W-1:0] PC_ITER = 4'd1;
  localparam logic [PC_W-1:0] PC_MIX  = 4'd9;

  // program rom
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw           = '0;
    uw.acc_op    = ACC_NONE;
    uw.jmp       = JMP_NONE;
    uw.mix_wheel = WHEEL_A;
    uw.rnd_wheel = WHEEL_A;
    case (pc)
      4'd0: begin
        uw.init   = 1'b1;
        uw.jmp    = JMP_NO_ROT;
        uw.target = PC_MIX;
      end
      4'd1: begin
        uw.iter   = 1'b1;
        uw.jmp    = JMP_ITER_MORE;
        uw.target = PC_ITER;
      end
      4'd2: begin
        uw.mul_en = 1'b1;
      end
      4'd3: begin
        uw.mul_en = 1'b1;
        uw.mul_hi = 1'b1;
        uw.acc_op = ACC_LOAD;
      end
      4'd4: begin
        uw.acc_op = ACC_ADD;
      end
      4'd5: begin
        uw.fin_en    = 1'b1;
        uw.mul_en    = 1'b1;
        uw.mul_src_y = 1'b1;
      end
      4'd6: begin
        uw.mul_en    = 1'b1;
        uw.mul_hi    = 1'b1;
        uw.mul_src_y = 1'b1;
        uw.acc_op    = ACC_LOAD;
      end
      4'd7: begin
        uw.acc_op = ACC_ADD;
      end
      4'd8: begin
        uw.fin_en = 1'b1;
        uw.fin_y  = 1'b1;
      end
      4'd9: begin
        uw.mix_mul   = 1'b1;
        uw.mix_wheel = WHEEL_A;
      end
      4'd10: begin
        uw.mix_mul   = 1'b1;
        uw.mix_wheel = WHEEL_B;
        uw.mix_rnd   = 1'b1;
        uw.rnd_wheel = WHEEL_A;
      end
      4'd11: begin
        uw.mix_mul   = 1'b1;
        uw.mix_wheel = WHEEL_C;
        uw.mix_rnd   = 1'b1;
        uw.rnd_wheel = WHEEL_B;
      end
      4'd12: begin
        uw.mix_mul   = 1'b1;
        uw.mix_wheel = WHEEL_D;
        uw.mix_rnd   = 1'b1;
        uw.rnd_wheel = WHEEL_C;
      end
      4'd13: begin
        uw.mix_rnd   = 1'b1;
        uw.rnd_wheel = WHEEL_D;
      end
      default: begin
        uw.last = 1'b1;
      end
    endcase
    return uw;
  endfunction

  // arctan(2^-i) in units of 2^32 per turn
  function automatic logic [30:0] ang_step(input logic [IterW-1:0] i);
    logic [30:0] a;
    case (i)
      5'd0:    a = 31'd536870912;
      5'd1:    a = 31'd316933406;
      5'd2:    a = 31'd167458907;
      5'd3:    a = 31'd85004756;
      5'd4:    a = 31'd42667331;
      5'd5:    a = 31'd21354465;
      5'd6:    a = 31'd10679838;
      5'd7:    a = 31'd5340245;
      5'd8:    a = 31'd2670163;
      5'd9:    a = 31'd1335087;
      5'd10:   a = 31'd667544;
      5'd11:   a = 31'd333772;
      5'd12:   a = 31'd166886;
      5'd13:   a = 31'd83443;
      5'd14:   a = 31'd41722;
      5'd15:   a = 31'd20861;
      5'd16:   a = 31'd10430;
      5'd17:   a = 31'd5215;
      5'd18:   a = 31'd2608;
      5'd19:   a = 31'd1304;
      5'd20:   a = 31'd652;
      5'd21:   a = 31'd326;
      5'd22:   a = 31'd163;
      5'd23:   a = 31'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

FILE: design/ocfrm_dp.sv
// ----------------------------------------------------------------------------
// ocfrm_dp
// datapath: command latch, cordic rotator, gain scaler and wheel mixer
// ----------------------------------------------------------------------------
`default_nettype none

module ocfrm_dp (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire logic                                            load,
  input  wire logic signed [ocfrm_pkg::CMD_W-1:0]              cmd_vx,
  input  wire logic signed [ocfrm_pkg::CMD_W-1:0]              cmd_vy,
  input  wire logic signed [ocfrm_pkg::CMD_W-1:0]              yaw_offset,
  input  wire ocfrm_pkg::mode_t                                drive_mode,
  input  wire logic                                            link_lost,
  input  wire logic [ocfrm_pkg::NUM_WHEELS-1:0][ocfrm_pkg::GAIN_W-1:0] gains,
  input  wire ocfrm_pkg::ucode_t                               ctl,
  output ocfrm_pkg::dp_stat_t                                  stat,
  output logic [ocfrm_pkg::NUM_WHEELS-1:0][ocfrm_pkg::SET_W-1:0] set_out
);
  import ocfrm_pkg::*;

  // latched command
  logic signed [CMD_W-1:0] vx_r, vy_r, yaw_r;
  mode_t                   mode_r;
  logic                    lost_r;

  // rotator state
  logic signed [VEC_W-1:0] x_r, y_r;
  logic signed [ANG_W-1:0] z_r;
  logic [IterW-1:0]        iter_r;

  // scaler and mixer
  logic signed [P_W-1:0]    p_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [HELD_W-1:0] held_vx_r, held_vy_r;
  logic signed [MP_W-1:0]   mp_r;
  logic [NUM_WHEELS-1:0][SET_W-1:0] set_r;

  // init terms
  logic signed [CMD_W-1:0] phi, phi_adj;
  logic                    flip;
  logic signed [VEC_W-1:0] vx_sc, vy_sc;
  logic                    rot_mode, clear_held;

  always_comb begin
    phi      = CMD_W'(~yaw_r + 1'b1);
    flip     = (phi > 16'sd16384) || (phi < -16'sd16384);
    phi_adj  = flip ? (phi ^ 16'sh8000) : phi;
    vx_sc    = {{(VEC_W-CMD_W-14){vx_r[CMD_W-1]}}, vx_r, 14'b0};
    vy_sc    = {{(VEC_W-CMD_W-14){vy_r[CMD_W-1]}}, vy_r, 14'b0};
    rot_mode = mode_r inside {MODE_NO_FOLLOW, MODE_FOLLOW_YAW};
    clear_held = lost_r || (mode_r == MODE_STOP);
  end

  assign stat.no_rot    = lost_r || !rot_mode;
  assign stat.iter_more = (iter_r != IterW'(CORDIC_STEPS - 1));

  // one micro-rotation
  logic signed [VEC_W-1:0] dx, dy;
  logic signed [ANG_W-1:0] ang;

  always_comb begin
    dx  = y_r >>> iter_r;
    dy  = x_r >>> iter_r;
    ang = $signed({2'b00, ang_step(iter_r)});
  end

  // scaler multiply operands
  logic signed [VEC_W-1:0]   mul_src;
  logic signed [KPART_W:0]   kop;
  logic signed [Q_W-1:0]     q;
  logic signed [HELD_W-1:0]  held_sat;

  always_comb begin
    mul_src = ctl.mul_src_y ? y_r : x_r;
    kop     = $signed({1'b0, ctl.mul_hi ? CORDIC_K[2*KPART_W-1:KPART_W]
                                        : CORDIC_K[KPART_W-1:0]});
    q       = acc_r[ACC_W-1:ACC_SHIFT];
    if (q > HELD_MAX_Q) begin
      held_sat = HELD_MAX;
    end else if (q < HELD_MIN_Q) begin
      held_sat = HELD_MIN;
    end else begin
      held_sat = q[HELD_W-1:0];
    end
  end

  // wheel sum and rounding
  logic signed [SUM_W-1:0]  hx, hy, wsum;
  logic signed [GAIN_W:0]   gop;
  logic signed [MP_W-1:0]   mp_rnd;
  logic signed [RND_W-1:0]  rv;
  logic [SET_W-1:0]         set_sat;

  always_comb begin
    hx = SUM_W'(held_vx_r);
    hy = SUM_W'(held_vy_r);
    case (ctl.mix_wheel)
      WHEEL_A: wsum = hx + hy;
      WHEEL_B: wsum = hy - hx;
      WHEEL_C: wsum = -hx - hy;
      WHEEL_D: wsum = hx - hy;
      default: wsum = '0;
    endcase
    gop    = $signed({1'b0, gains[ctl.mix_wheel]});
    mp_rnd = mp_r + MP_W'(128);
    rv     = mp_rnd[MP_W-1:8];
    if (rv > SET_MAX_R) begin
      set_sat = SET_MAX;
    end else if (rv < SET_MIN_R) begin
      set_sat = SET_MIN;
    end else begin
      set_sat = rv[SET_W-1:0];
    end
  end

  // command latch on input transfer
  always_ff @(posedge clk) begin
    if (load) begin
      vx_r   <= cmd_vx;
      vy_r   <= cmd_vy;
      yaw_r  <= yaw_offset;
      mode_r <= drive_mode;
      lost_r <= link_lost;
    end
  end

  // rotator registers
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      x_r    <= flip ? -vx_sc : vx_sc;
      y_r    <= flip ? -vy_sc : vy_sc;
      z_r    <= {{(ANG_W-CMD_W-16){phi_adj[CMD_W-1]}}, phi_adj, 16'b0};
      iter_r <= '0;
    end else if (ctl.iter) begin
      if (!z_r[ANG_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - ang;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + ang;
      end
      iter_r <= IterW'(iter_r + 1'b1);
    end
  end

  // gain scaling by cordic constant in two partial products
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      p_r <= mul_src * kop;
    end
    case (ctl.acc_op)
      ACC_LOAD: acc_r <= ACC_W'(p_r) + ACC_ROUND;
      ACC_ADD:  acc_r <= acc_r + (ACC_W'(p_r) <<< KPART_W);
      default:  acc_r <= acc_r;
    endcase
  end

  // held reference
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vx_r <= '0;
      held_vy_r <= '0;
    end else if (ctl.init) begin
      if (clear_held) begin
        held_vx_r <= '0;
        held_vy_r <= '0;
      end
    end else if (ctl.fin_en) begin
      if (ctl.fin_y) begin
        held_vy_r <= held_sat;
      end else begin
        held_vx_r <= held_sat;
      end
    end
  end

  // wheel mixer
  always_ff @(posedge clk) begin
    if (ctl.mix_mul) begin
      mp_r <= wsum * gop;
    end
    if (ctl.mix_rnd) begin
      set_r[ctl.rnd_wheel] <= set_sat;
    end
  end

  assign set_out = set_r;

endmodule

`default_nettype wire

FILE: design/omni_chassis_frame_rotate_mix.sv
// ----------------------------------------------------------------------------
// omni_chassis_frame_rotate_mix
// yaw rotation of a velocity command and four-wheel omni setpoint mixing
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one command per transfer, velocities and yaw in in_tdata,
//           drive mode and link-lost flag in in_tuser
//   out_* : one transfer of four Q16.8 wheel setpoints per command
//   cfg_* : per-wheel gain writes, index 0 to 3, other indexes ignored;
//           cfg_ready is always high, write only while the block is idle
// Timing
//   a microcoded sequencer runs a 15-step program over a shared datapath;
//   the cordic step repeats 16 times for a command in no-follow or
//   follow-yaw mode; stop, link-lost and keep-held commands skip the
//   rotation and scaling and go straight to the mixer steps; a new
//   command is taken only after the result is loaded into the output
//   register, so commands are worked one at a time
// Reset
//   held reference and all gains clear, sequencer idle, no result pending
// Stall
//   a result waits in the output register while a new command is worked;
//   if that command finishes before the old result is taken, the program
//   parks on its last step and in_tready stays low
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module omni_chassis_frame_rotate_mix (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // cmd_vx[15:0], cmd_vy[31:16], yaw_offset[47:32]
  input  wire logic [47:0] in_tdata,
  // drive_mode[1:0], link_lost[2]
  input  wire logic [2:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // wheel_a_set[23:0], wheel_b_set[47:24], wheel_c_set[71:48],
  // wheel_d_set[95:72]
  output logic [95:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ocfrm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ocfrm_pkg::GAIN_W-1:0]    cfg_data
);
  import ocfrm_pkg::*;

  seq_state_t      state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucode_t          uw, ctl;
  dp_stat_t        stat;
  logic            in_xfer, out_load, out_free, jump_taken;
  logic            out_valid_r;
  logic [95:0]     out_data_r;
  logic [NUM_WHEELS-1:0][GAIN_W-1:0] gains_r;
  logic [NUM_WHEELS-1:0][SET_W-1:0]  set_w;

  assign in_tready  = (state_r == SEQ_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // gain registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r <= '0;
    end else if (cfg_valid && cfg_ready && (cfg_index <= REG_GAIN_D)) begin
      gains_r[cfg_index[1:0] - REG_GAIN_A[1:0]] <= cfg_data;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= PC_INIT;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

  // sequencer next step and datapath control
  always_comb begin
    uw         = ucode_rom(pc_r);
    ctl        = '0;
    ctl.acc_op = ACC_NONE;
    ctl.jmp    = JMP_NONE;
    state_nxt  = state_r;
    pc_nxt     = pc_r;
    out_free   = !out_valid_r || out_tready;
    out_load   = 1'b0;
    jump_taken = ((uw.jmp == JMP_NO_ROT) && stat.no_rot) ||
                 ((uw.jmp == JMP_ITER_MORE) && stat.iter_more);
    case (state_r)
      SEQ_IDLE: begin
        if (in_xfer) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = PC_INIT;
        end
      end
      SEQ_RUN: begin
        ctl = uw;
        if (uw.last) begin
          if (out_free) begin
            out_load  = 1'b1;
            state_nxt = SEQ_IDLE;
            pc_nxt    = PC_INIT;
          end
        end else begin
          pc_nxt = jump_taken ? uw.target : PC_W'(pc_r + 1'b1);
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
        pc_nxt    = PC_INIT;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= set_w;
    end
  end

  ocfrm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_xfer),
    .cmd_vx     ($signed(in_tdata[15:0])),
    .cmd_vy     ($signed(in_tdata[31:16])),
    .yaw_offset ($signed(in_tdata[47:32])),
    .drive_mode (mode_t'(in_tuser[1:0])),
    .link_lost  (in_tuser[2]),
    .gains      (gains_r),
    .ctl        (ctl),
    .stat       (stat),
    .set_out    (set_w)
  );

  // checks
  `ASSERT_CLK(a_accept_starts, clk, rst_n, in_xfer |=> (state_r == SEQ_RUN) && (pc_r == PC_INIT))
  `ASSERT_CLK(a_run_until_last, clk, rst_n, (state_r == SEQ_RUN) && !uw.last |=> state_r == SEQ_RUN)
  `ASSERT_CLK(a_park_on_stall, clk, rst_n, (state_r == SEQ_RUN) && uw.last && !out_free |=> (state_r == SEQ_RUN) && $stable(pc_r))
  `ASSERT_CLK(a_result_shown, clk, rst_n, (state_r == SEQ_RUN) && uw.last && out_free |=> out_valid_r)

endmodule

`default_nettype wire
